/* design/tsdz_pkg.sv */
`default_nettype none
// ============================================================================
// Thumbstick radial dead zone and cardinal snap: shared definitions
// Widths, register indexes, arctangent table and the sideband records that
// travel with each transaction through the pipeline.
// ============================================================================
package tsdz_pkg;

  // Field widths fixed by the interface.
  localparam int RAW_W = 16;
  localparam int OUT_W = 16;
  localparam int DZ_W  = 15;
  localparam int SW_W  = 14;
  localparam int ANG_W = 16;
  localparam int M2_W  = 32;
  localparam int ROOT_W = 24;
  localparam int MAG_MAX_W = 16;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 15;
  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SNAP_WINDOW = 1'b1;

  localparam logic [DZ_W-1:0] DZ_RESET = 15'd10813;
  localparam logic [SW_W-1:0] SW_RESET = 14'd1820;

  // Full scale of one axis and its square.
  localparam logic [DZ_W-1:0] FULL_SCALE    = 15'd32767;
  localparam logic [M2_W-1:0] FULL_SCALE_SQ = 32'd1073676289;

  // Half a turn in the 2^32-per-turn angle accumulator.
  localparam logic [31:0] Z_HALF_TURN = 32'h8000_0000;
  localparam logic [31:0] Z_ROUND     = 32'h0000_8000;

  typedef enum logic [2:0] {
    SNAP_NONE,
    SNAP_EAST,
    SNAP_SOUTH,
    SNAP_WEST,
    SNAP_NORTH
  } snap_t;

  // Sideband carried through the angle pipeline.
  typedef struct packed {
    logic signed [RAW_W-1:0] x;
    logic signed [RAW_W-1:0] y;
    logic [M2_W-1:0]         m2;
    logic                    dead;
    logic                    capped;
  } front_sb_t;

  // Sideband carried through the square root pipeline.
  typedef struct packed {
    logic signed [RAW_W-1:0] x;
    logic signed [RAW_W-1:0] y;
    logic                    dead;
    logic                    capped;
    snap_t                   snap;
  } root_sb_t;

  // Sideband carried through the magnitude divider.
  typedef struct packed {
    logic signed [RAW_W-1:0] x;
    logic signed [RAW_W-1:0] y;
    logic                    dead;
    logic                    capped;
    snap_t                   snap;
    logic [ROOT_W-1:0]       root;
  } mag_sb_t;

  // Sideband carried through the component dividers.
  typedef struct packed {
    logic                 neg_x;
    logic                 dead;
    snap_t                snap;
    logic [MAG_MAX_W-1:0] mag;
    logic                 root_zero;
  } comp_sb_t;

  // One finished result.
  typedef struct packed {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic                    dead;
  } result_t;

  // atan(2^-i) in 2^32-per-turn units.
  function automatic logic [31:0] atan_entry(input int idx);
    case (idx)
      0:  return 32'd536870912;
      1:  return 32'd316933406;
      2:  return 32'd167458905;
      3:  return 32'd85004756;
      4:  return 32'd42667331;
      5:  return 32'd21354465;
      6:  return 32'd10679838;
      7:  return 32'd5340245;
      8:  return 32'd2670163;
      9:  return 32'd1335087;
      10: return 32'd667544;
      11: return 32'd333772;
      12: return 32'd166886;
      13: return 32'd83443;
      14: return 32'd41722;
      15: return 32'd20861;
      16: return 32'd10430;
      17: return 32'd5215;
      18: return 32'd2608;
      19: return 32'd1304;
      20: return 32'd652;
      21: return 32'd326;
      22: return 32'd163;
      23: return 32'd81;
      default: return 32'd0;
    endcase
  endfunction

endpackage
`default_nettype wire

/* design/tsdz_cordic.sv */
`default_nettype none
// ============================================================================
// Vectoring CORDIC angle pipeline
// One register stage for the half-turn pre-rotation, then one stage per
// micro-rotation. Produces atan2 in 65536-per-turn units.
// ============================================================================
module tsdz_cordic #(
  parameter int STEPS = 16,
  parameter int SBW   = 1
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic signed [tsdz_pkg::RAW_W-1:0]   in_x,
  input  logic signed [tsdz_pkg::RAW_W-1:0]   in_y,
  input  logic [SBW-1:0]                      in_sb,
  output logic                                out_valid,
  output logic signed [tsdz_pkg::ANG_W-1:0]   out_angle,
  output logic [SBW-1:0]                      out_sb
);
  import tsdz_pkg::*;

  localparam int XW = 27;

  logic signed [XW-1:0] x_r [0:STEPS];
  logic signed [XW-1:0] y_r [0:STEPS];
  logic [31:0]          z_r [0:STEPS];
  logic                 v_r [0:STEPS];
  logic [SBW-1:0]       sb_r [0:STEPS];

  logic signed [XW-1:0] x_ext;
  logic signed [XW-1:0] y_ext;
  logic [31:0]          z_round;

  // Scale the sample by 256 before rotating.
  assign x_ext = XW'(in_x) <<< 8;
  assign y_ext = XW'(in_y) <<< 8;

  // Pre-rotation: a vector in the left half plane is turned by half a turn.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_r[0] <= in_sb;
      if (in_x < 0) begin
        x_r[0] <= -x_ext;
        y_r[0] <= -y_ext;
        z_r[0] <= Z_HALF_TURN;
      end else begin
        x_r[0] <= x_ext;
        y_r[0] <= y_ext;
        z_r[0] <= '0;
      end
    end
  end

  // Micro-rotation stages, each turning the vector towards the x axis.
  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic signed [XW-1:0] xsh;
    logic signed [XW-1:0] ysh;

    assign xsh = x_r[i] >>> i;
    assign ysh = y_r[i] >>> i;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (en) begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sb_r[i+1] <= sb_r[i];
        if (!y_r[i][XW-1]) begin
          x_r[i+1] <= x_r[i] + ysh;
          y_r[i+1] <= y_r[i] - xsh;
          z_r[i+1] <= z_r[i] + atan_entry(i);
        end else begin
          x_r[i+1] <= x_r[i] - ysh;
          y_r[i+1] <= y_r[i] + xsh;
          z_r[i+1] <= z_r[i] - atan_entry(i);
        end
      end
    end
  end

  // Round the accumulated angle to 16 bits.
  assign z_round   = z_r[STEPS] + Z_ROUND;
  assign out_angle = signed'(z_round[31:16]);
  assign out_valid = v_r[STEPS];
  assign out_sb    = sb_r[STEPS];

endmodule
`default_nettype wire

/* design/tsdz_isqrt.sv */
`default_nettype none
// ============================================================================
// Pipelined integer square root
// Returns floor(sqrt(m2 * 65536)), one result bit resolved per stage.
// ============================================================================
module tsdz_isqrt #(
  parameter int SBW = 1
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic [tsdz_pkg::M2_W-1:0]          in_m2,
  input  logic [SBW-1:0]                     in_sb,
  output logic                               out_valid,
  output logic [tsdz_pkg::ROOT_W-1:0]        out_root,
  output logic [SBW-1:0]                     out_sb
);
  import tsdz_pkg::*;

  localparam int VW     = M2_W + 16;
  localparam int STAGES = VW / 2;

  logic [VW-1:0]  rem_r [0:STAGES-1];
  logic [VW-1:0]  res_r [0:STAGES];
  logic           v_r   [0:STAGES];
  logic [SBW-1:0] sb_r  [0:STAGES];

  // Input stage: the radicand is the squared magnitude scaled by 65536.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= {in_m2, 16'd0};
      res_r[0] <= '0;
      sb_r[0]  <= in_sb;
    end
  end

  // Digit-by-digit stages, from the top pair of bits downwards.
  for (genvar j = 0; j < STAGES; j++) begin : g_stage
    localparam logic [VW-1:0] ONE_J = VW'(1) << (VW - 2 - 2 * j);
    logic [VW-1:0] trial;
    logic          take;

    assign trial = res_r[j] + ONE_J;
    assign take  = rem_r[j] >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j+1] <= 1'b0;
      end else if (en) begin
        v_r[j+1] <= v_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sb_r[j+1] <= sb_r[j];
        if (take) begin
          res_r[j+1] <= (res_r[j] >> 1) + ONE_J;
        end else begin
          res_r[j+1] <= res_r[j] >> 1;
        end
      end
    end

    if (j < STAGES - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[j+1] <= take ? (rem_r[j] - trial) : rem_r[j];
        end
      end
    end
  end

  assign out_valid = v_r[STAGES];
  assign out_root  = res_r[STAGES][ROOT_W-1:0];
  assign out_sb    = sb_r[STAGES];

endmodule
`default_nettype wire

/* design/tsdz_div.sv */
`default_nettype none
// ============================================================================
// Pipelined restoring divider
// Unsigned quotient of num / den, one quotient bit resolved per stage. The
// quotient must fit in QW bits.
// ============================================================================
module tsdz_div #(
  parameter int NW  = 40,
  parameter int DW  = 24,
  parameter int QW  = 16,
  parameter int SBW = 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  logic [NW-1:0]  in_num,
  input  logic [DW-1:0]  in_den,
  input  logic [SBW-1:0] in_sb,
  output logic           out_valid,
  output logic [QW-1:0]  out_quot,
  output logic [SBW-1:0] out_sb
);

  localparam int W = (NW > DW + QW) ? NW : DW + QW;

  logic [W-1:0]   rem_r [0:QW-1];
  logic [DW-1:0]  den_r [0:QW-1];
  logic [QW-1:0]  q_r   [0:QW];
  logic           v_r   [0:QW];
  logic [SBW-1:0] sb_r  [0:QW];

  // Input stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= W'(in_num);
      den_r[0] <= in_den;
      q_r[0]   <= '0;
      sb_r[0]  <= in_sb;
    end
  end

  // Each stage tries the divisor shifted to the next lower quotient bit.
  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int K = QW - 1 - s;
    logic [W-1:0] dsh;
    logic         take;

    assign dsh  = W'(den_r[s]) << K;
    assign take = rem_r[s] >= dsh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s+1] <= 1'b0;
      end else if (en) begin
        v_r[s+1] <= v_r[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sb_r[s+1] <= sb_r[s];
        q_r[s+1]  <= take ? (q_r[s] | (QW'(1) << K)) : q_r[s];
      end
    end

    if (s < QW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s+1] <= take ? (rem_r[s] - dsh) : rem_r[s];
          den_r[s+1] <= den_r[s];
        end
      end
    end
  end

  assign out_valid = v_r[QW];
  assign out_quot  = q_r[QW];
  assign out_sb    = sb_r[QW];

endmodule
`default_nettype wire

/* design/thumbstick_radial_deadzone_snap.sv */
`default_nettype none
// ============================================================================
// Thumbstick radial dead zone with cardinal snap
// Turns a raw stick sample into a rescaled direction vector in fixed point,
// zeroed inside the dead zone and snapped onto an axis near the cardinals.
// ============================================================================
//
//  Channel   Direction  Handshake            Payload
//  in_       input      in_valid / in_stall  in_raw_x, in_raw_y
//  out_      output     out_valid/out_stall  out_x, out_y, out_in_dead_zone
//  cfg_      input      cfg_valid/cfg_ready  cfg_index, cfg_wdata
//
//  One transaction is accepted per cycle while in_stall is low. Each one
//  passes through the CORDIC stages, the 24 square root stages and two
//  dividers in series. Reset clears all valid bits and loads the register
//  defaults; no sweep. A two-entry output buffer holds finished results;
//  the pipeline freezes as a whole only when both entries are occupied.
//
module thumbstick_radial_deadzone_snap #(
  parameter int CORDIC_STEPS  = 16,
  parameter int OUT_FRAC_BITS = 14
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [tsdz_pkg::RAW_W-1:0]    in_raw_x,
  input  logic signed [tsdz_pkg::RAW_W-1:0]    in_raw_y,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [tsdz_pkg::OUT_W-1:0]    out_x,
  output logic signed [tsdz_pkg::OUT_W-1:0]    out_y,
  output logic                                 out_in_dead_zone,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tsdz_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tsdz_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import tsdz_pkg::*;

  localparam int F       = OUT_FRAC_BITS;
  localparam int MAG_W   = F + 1;
  localparam int Q_W     = F + 2;
  localparam int PROD_W  = MAG_W + RAW_W;
  localparam int MNW     = ROOT_W + F + 2;
  localparam int MDW     = DZ_W + 9;
  localparam int CNW     = PROD_W + 10;
  localparam int CDW     = ROOT_W + 1;
  localparam int LIM     = ((1 << F) > 32767) ? 32767 : (1 << F);
  localparam logic [MAG_W-1:0]     MAG_FULL = MAG_W'(1) << F;
  localparam logic [Q_W-1:0]       Q_FULL   = Q_W'(1) << F;
  localparam logic [Q_W-1:0]       Q_LIM    = Q_W'(LIM);
  localparam logic [MAG_MAX_W-1:0] M_LIM    = MAG_MAX_W'(LIM);
  localparam logic [1:0]           BUF_FULL = 2'd2;
  localparam logic signed [18:0]   QTR_TURN = 19'sd16384;
  localparam logic signed [18:0]   HALF_TURN = 19'sd32768;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [DZ_W-1:0]   dz_r;
  logic [SW_W-1:0]   sw_r;
  logic [2*DZ_W-1:0] dz2_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dz_r <= DZ_RESET;
      sw_r <= SW_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DEAD_ZONE:   dz_r <= cfg_wdata[DZ_W-1:0];
        CFG_SNAP_WINDOW: sw_r <= cfg_wdata[SW_W-1:0];
        default: ;
      endcase
    end
  end

  // Squared dead-zone radius, kept ready for the threshold compare.
  always_ff @(posedge clk) begin
    dz2_r <= dz_r * dz_r;
  end

  // --------------------------------------------------------------------------
  // Pipeline hold and input acceptance
  // --------------------------------------------------------------------------
  logic [1:0] cnt_r;
  logic       en;
  logic       in_fire;

  assign en       = cnt_r != BUF_FULL;
  assign in_stall = !en;
  assign in_fire  = in_valid && !in_stall;

  // --------------------------------------------------------------------------
  // Stage A: axis squares
  // --------------------------------------------------------------------------
  logic                    a_valid_r;
  logic signed [RAW_W-1:0] a_x_r;
  logic signed [RAW_W-1:0] a_y_r;
  logic [M2_W-1:0]         a_xx_r;
  logic [M2_W-1:0]         a_yy_r;
  logic signed [M2_W-1:0]  sq_x;
  logic signed [M2_W-1:0]  sq_y;

  assign sq_x = in_raw_x * in_raw_x;
  assign sq_y = in_raw_y * in_raw_y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_x_r  <= in_raw_x;
      a_y_r  <= in_raw_y;
      a_xx_r <= unsigned'(sq_x);
      a_yy_r <= unsigned'(sq_y);
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: squared magnitude, dead zone and full-scale tests
  // --------------------------------------------------------------------------
  logic            b_valid_r;
  front_sb_t       b_sb_r;
  logic [M2_W-1:0] m2;

  assign m2 = a_xx_r + a_yy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (en) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_sb_r.x      <= a_x_r;
      b_sb_r.y      <= a_y_r;
      b_sb_r.m2     <= m2;
      b_sb_r.dead   <= m2 < M2_W'(dz2_r);
      b_sb_r.capped <= (m2 > FULL_SCALE_SQ) || (dz_r == FULL_SCALE);
    end
  end

  // --------------------------------------------------------------------------
  // Angle pipeline
  // --------------------------------------------------------------------------
  logic                        cor_valid;
  logic signed [ANG_W-1:0]     cor_angle;
  logic [$bits(front_sb_t)-1:0] cor_sb_vec;
  front_sb_t                   cor_sb;

  tsdz_cordic #(
    .STEPS (CORDIC_STEPS),
    .SBW   ($bits(front_sb_t))
  ) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (b_valid_r),
    .in_x      (b_sb_r.x),
    .in_y      (b_sb_r.y),
    .in_sb     (b_sb_r),
    .out_valid (cor_valid),
    .out_angle (cor_angle),
    .out_sb    (cor_sb_vec)
  );

  assign cor_sb = front_sb_t'(cor_sb_vec);

  // --------------------------------------------------------------------------
  // Stage C: cardinal snap decision, first match east, south, west, north
  // --------------------------------------------------------------------------
  logic              c_valid_r;
  root_sb_t          c_sb_r;
  logic [M2_W-1:0]   c_m2_r;
  logic signed [18:0] ang_s;
  logic signed [18:0] win_s;
  snap_t             snap;

  assign ang_s = {{3{cor_angle[ANG_W-1]}}, cor_angle};
  assign win_s = {5'd0, sw_r};

  always_comb begin
    if (ang_s >= -win_s && ang_s <= win_s) begin
      snap = SNAP_EAST;
    end else if (ang_s >= QTR_TURN - win_s && ang_s <= QTR_TURN + win_s) begin
      snap = SNAP_SOUTH;
    end else if (ang_s >= HALF_TURN - win_s || ang_s <= -HALF_TURN + win_s) begin
      snap = SNAP_WEST;
    end else if (ang_s >= -QTR_TURN - win_s && ang_s <= -QTR_TURN + win_s) begin
      snap = SNAP_NORTH;
    end else begin
      snap = SNAP_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else if (en) begin
      c_valid_r <= cor_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_sb_r.x      <= cor_sb.x;
      c_sb_r.y      <= cor_sb.y;
      c_sb_r.dead   <= cor_sb.dead;
      c_sb_r.capped <= cor_sb.capped;
      c_sb_r.snap   <= snap;
      c_m2_r        <= cor_sb.m2;
    end
  end

  // --------------------------------------------------------------------------
  // Square root of the scaled magnitude
  // --------------------------------------------------------------------------
  logic                        sq_valid;
  logic [ROOT_W-1:0]           sq_root;
  logic [$bits(root_sb_t)-1:0] sq_sb_vec;
  root_sb_t                    sq_sb;

  tsdz_isqrt #(
    .SBW ($bits(root_sb_t))
  ) u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (c_valid_r),
    .in_m2     (c_m2_r),
    .in_sb     (c_sb_r),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_sb    (sq_sb_vec)
  );

  assign sq_sb = root_sb_t'(sq_sb_vec);

  // --------------------------------------------------------------------------
  // Stage D: rounded rescale operands (root - 256*dz) / (256*(full - dz))
  // --------------------------------------------------------------------------
  logic              d_valid_r;
  logic [MNW-1:0]    d_num_r;
  logic [MDW-1:0]    d_den_r;
  mag_sb_t           d_sb_r;
  logic [DZ_W-1:0]   span;
  logic [ROOT_W-1:0] mag_diff;

  assign span     = FULL_SCALE - dz_r;
  assign mag_diff = sq_root - ROOT_W'({dz_r, 8'd0});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r <= 1'b0;
    end else if (en) begin
      d_valid_r <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_num_r       <= (MNW'(mag_diff) << (F + 1)) + MNW'({span, 8'd0});
      d_den_r       <= {span, 9'd0};
      d_sb_r.x      <= sq_sb.x;
      d_sb_r.y      <= sq_sb.y;
      d_sb_r.dead   <= sq_sb.dead;
      d_sb_r.capped <= sq_sb.capped;
      d_sb_r.snap   <= sq_sb.snap;
      d_sb_r.root   <= sq_root;
    end
  end

  logic                       md_valid;
  logic [Q_W-1:0]             md_quot;
  logic [$bits(mag_sb_t)-1:0] md_sb_vec;
  mag_sb_t                    md_sb;

  tsdz_div #(
    .NW  (MNW),
    .DW  (MDW),
    .QW  (Q_W),
    .SBW ($bits(mag_sb_t))
  ) u_mag_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (d_valid_r),
    .in_num    (d_num_r),
    .in_den    (d_den_r),
    .in_sb     (d_sb_r),
    .out_valid (md_valid),
    .out_quot  (md_quot),
    .out_sb    (md_sb_vec)
  );

  assign md_sb = mag_sb_t'(md_sb_vec);

  // --------------------------------------------------------------------------
  // Stage E: magnitude, capped at full scale
  // --------------------------------------------------------------------------
  logic             e_valid_r;
  logic [MAG_W-1:0] e_mag_r;
  mag_sb_t          e_sb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r <= 1'b0;
    end else if (en) begin
      e_valid_r <= md_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_sb_r <= md_sb;
      if (md_sb.capped || md_quot > Q_FULL) begin
        e_mag_r <= MAG_FULL;
      end else begin
        e_mag_r <= md_quot[MAG_W-1:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage F: magnitude times absolute axis values
  // --------------------------------------------------------------------------
  logic              f_valid_r;
  logic [PROD_W-1:0] f_prod_x_r;
  logic [PROD_W-1:0] f_prod_y_r;
  logic [ROOT_W-1:0] f_root_r;
  logic              f_neg_y_r;
  comp_sb_t          f_sb_r;
  logic [RAW_W-1:0]  abs_x;
  logic [RAW_W-1:0]  abs_y;

  assign abs_x = e_sb_r.x[RAW_W-1] ? RAW_W'(-e_sb_r.x) : RAW_W'(e_sb_r.x);
  assign abs_y = e_sb_r.y[RAW_W-1] ? RAW_W'(-e_sb_r.y) : RAW_W'(e_sb_r.y);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (en) begin
      f_valid_r <= e_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_prod_x_r       <= e_mag_r * abs_x;
      f_prod_y_r       <= e_mag_r * abs_y;
      f_root_r         <= e_sb_r.root;
      f_neg_y_r        <= e_sb_r.y[RAW_W-1];
      f_sb_r.neg_x     <= e_sb_r.x[RAW_W-1];
      f_sb_r.dead      <= e_sb_r.dead;
      f_sb_r.snap      <= e_sb_r.snap;
      f_sb_r.mag       <= MAG_MAX_W'(e_mag_r);
      f_sb_r.root_zero <= e_sb_r.root == '0;
    end
  end

  // --------------------------------------------------------------------------
  // Component dividers: round(mag * |raw| * 256 / root)
  // --------------------------------------------------------------------------
  logic [CNW-1:0]              cx_num;
  logic [CNW-1:0]              cy_num;
  logic [CDW-1:0]              c_den;
  logic                        cx_valid;
  logic                        cy_valid;
  logic [Q_W-1:0]              cx_quot;
  logic [Q_W-1:0]              cy_quot;
  logic [$bits(comp_sb_t)-1:0] cx_sb_vec;
  comp_sb_t                    cx_sb;
  logic                        cy_neg;

  assign cx_num = (CNW'(f_prod_x_r) << 9) + CNW'(f_root_r);
  assign cy_num = (CNW'(f_prod_y_r) << 9) + CNW'(f_root_r);
  assign c_den  = {f_root_r, 1'b0};

  tsdz_div #(
    .NW  (CNW),
    .DW  (CDW),
    .QW  (Q_W),
    .SBW ($bits(comp_sb_t))
  ) u_x_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (f_valid_r),
    .in_num    (cx_num),
    .in_den    (c_den),
    .in_sb     (f_sb_r),
    .out_valid (cx_valid),
    .out_quot  (cx_quot),
    .out_sb    (cx_sb_vec)
  );

  tsdz_div #(
    .NW  (CNW),
    .DW  (CDW),
    .QW  (Q_W),
    .SBW (1)
  ) u_y_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (f_valid_r),
    .in_num    (cy_num),
    .in_den    (c_den),
    .in_sb     (f_neg_y_r),
    .out_valid (cy_valid),
    .out_quot  (cy_quot),
    .out_sb    (cy_neg)
  );

  assign cx_sb = comp_sb_t'(cx_sb_vec);

  // --------------------------------------------------------------------------
  // Final selection: dead zone, snapped axis or scaled components
  // --------------------------------------------------------------------------
  logic [MAG_MAX_W-1:0] cx_mag;
  logic [MAG_MAX_W-1:0] cy_mag;
  logic [MAG_MAX_W-1:0] snap_mag;
  result_t              res;

  always_comb begin
    if (cx_sb.root_zero) begin
      cx_mag = '0;
      cy_mag = '0;
    end else begin
      cx_mag = (cx_quot > Q_LIM) ? M_LIM : MAG_MAX_W'(cx_quot);
      cy_mag = (cy_quot > Q_LIM) ? M_LIM : MAG_MAX_W'(cy_quot);
    end
    snap_mag = (cx_sb.mag > M_LIM) ? M_LIM : cx_sb.mag;
  end

  always_comb begin
    res.dead = 1'b0;
    res.x    = '0;
    res.y    = '0;
    if (cx_sb.dead) begin
      res.dead = 1'b1;
    end else begin
      case (cx_sb.snap)
        SNAP_EAST:  res.x = signed'(snap_mag);
        SNAP_WEST:  res.x = signed'(MAG_MAX_W'(0) - snap_mag);
        SNAP_SOUTH: res.y = signed'(snap_mag);
        SNAP_NORTH: res.y = signed'(MAG_MAX_W'(0) - snap_mag);
        default: begin
          res.x = signed'(cx_sb.neg_x ? (MAG_MAX_W'(0) - cx_mag) : cx_mag);
          res.y = signed'(cy_neg ? (MAG_MAX_W'(0) - cy_mag) : cy_mag);
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Two-entry output buffer
  // --------------------------------------------------------------------------
  result_t    ent0_r;
  result_t    ent1_r;
  result_t    ent0_nxt;
  result_t    ent1_nxt;
  logic [1:0] cnt_nxt;
  logic       push;
  logic       pop;

  assign push = en && cx_valid;
  assign pop  = (cnt_r != 2'd0) && !out_stall;

  always_comb begin
    cnt_nxt  = cnt_r;
    ent0_nxt = ent0_r;
    ent1_nxt = ent1_r;
    case ({push, pop})
      2'b10: begin
        if (cnt_r == 2'd0) begin
          ent0_nxt = res;
        end else begin
          ent1_nxt = res;
        end
        cnt_nxt = cnt_r + 2'd1;
      end
      2'b01: begin
        ent0_nxt = ent1_r;
        cnt_nxt  = cnt_r - 2'd1;
      end
      2'b11: begin
        if (cnt_r == 2'd1) begin
          ent0_nxt = res;
        end else begin
          ent0_nxt = ent1_r;
          ent1_nxt = res;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent0_r <= ent0_nxt;
    ent1_r <= ent1_nxt;
  end

  assign out_valid        = cnt_r != 2'd0;
  assign out_x            = ent0_r.x;
  assign out_y            = ent0_r.y;
  assign out_in_dead_zone = ent0_r.dead;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_div_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    cx_valid == cy_valid)
    else $error("component dividers out of step");

  a_buf_count: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("output buffer count overflow");

  a_hold_tail: assert property (@(posedge clk) disable iff (!rst_n)
    !en && cx_valid |=> cx_valid)
    else $error("pipeline tail lost while frozen");

  a_dead_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_in_dead_zone |-> out_x == '0 && out_y == '0)
    else $error("dead zone result not zero");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_x <= LIM && out_x >= -LIM && out_y <= LIM && out_y >= -LIM)
    else $error("component outside clamp range");

endmodule
`default_nettype wire
